FILE: design/cme_pkg.sv
// Package for the complex matrix engine: widths, codes, defaults and the
// controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package cme_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 64;
    localparam int CFG_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MUL  = 2'd2,
        OP_KRON = 2'd3
    } t_op;

    // partial product select: re*re, im*im, re*im, im*re
    typedef enum logic [1:0] {
        PP_RR = 2'd0,
        PP_II = 2'd1,
        PP_RI = 2'd2,
        PP_IR = 2'd3
    } t_pp;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_DRAIN,
        ST_EMIT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic acc_clr;
        logic acc_load;
        logic load_sub;
        logic mul_go;
        t_pp  mul_sel;
        logic emit;
        logic emit_last;
        logic emit_err;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: design/cme_if.sv
// Handshake channels of the complex matrix engine: element input and result
// output. Depends on cme_pkg.
`timescale 1ns / 1ps

interface cme_in_if;
    import cme_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] elem_re;
    logic signed [DATA_W-1:0] elem_im;

    modport source (output valid, output elem_re, output elem_im, input ready);
    modport sink   (input valid, input elem_re, input elem_im, output ready);
endinterface

interface cme_out_if;
    import cme_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     last;
    logic                     shape_error;

    modport source (output valid, output out_re, output out_im, output last,
                    output shape_error, input ready);
    modport sink   (input valid, input out_re, input out_im, input last,
                    input shape_error, output ready);
endinterface

FILE: design/cme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/cme_datapath.sv
// Datapath: A/B element stores, one shared multiplier with rounding and
// accumulate stages, saturation and the result register.
// Depends on cme_pkg and cme_ram.
`timescale 1ns / 1ps

module cme_datapath #(
    parameter int MAX_DIM   = cme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cme_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  cme_pkg::t_dp_cmd                             i_cmd,
    output cme_pkg::t_dp_sts                             o_sts,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           i_wr_addr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           i_wr_addr_b,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           i_rd_addr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           i_rd_addr_b,
    input  logic signed [cme_pkg::DATA_W-1:0]            i_elem_re,
    input  logic signed [cme_pkg::DATA_W-1:0]            i_elem_im,
    input  logic                                         i_out_ready,
    output logic                                         o_out_valid,
    output logic signed [cme_pkg::DATA_W-1:0]            o_out_re,
    output logic signed [cme_pkg::DATA_W-1:0]            o_out_im,
    output logic                                         o_out_last,
    output logic                                         o_out_err
);
    import cme_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int EW    = 2 * DATA_W;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);

    logic [EW-1:0] rd_a, rd_b;
    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im, op_x, op_y;

    logic                    r_p1_vld, r_p2_vld;
    t_pp                     r_p1_sel, r_p2_sel;
    logic signed [ACC_W-1:0] r_prod, r_rnd;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;

    logic                     r_out_vld, r_out_last, r_out_err;
    logic signed [DATA_W-1:0] r_out_re, r_out_im;

    cme_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_a),
        .i_waddr(i_wr_addr_a),
        .i_wdata({i_elem_re, i_elem_im}),
        .i_raddr(i_rd_addr_a),
        .o_rdata(rd_a)
    );

    cme_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_b),
        .i_waddr(i_wr_addr_b),
        .i_wdata({i_elem_re, i_elem_im}),
        .i_raddr(i_rd_addr_b),
        .o_rdata(rd_b)
    );

    assign a_re = rd_a[EW-1:DATA_W];
    assign a_im = rd_a[DATA_W-1:0];
    assign b_re = rd_b[EW-1:DATA_W];
    assign b_im = rd_b[DATA_W-1:0];

    always_comb begin
        case (i_cmd.mul_sel)
            PP_RR:   begin op_x = a_re; op_y = b_re; end
            PP_II:   begin op_x = a_im; op_y = b_im; end
            PP_RI:   begin op_x = a_re; op_y = b_im; end
            default: begin op_x = a_im; op_y = b_re; end
        endcase
    end

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        if (v > SAT_MAX) begin
            return DATA_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return DATA_W'(SAT_MIN);
        end
        return v[DATA_W-1:0];
    endfunction

    // multiply, round (half up, floor), accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.mul_go;
            r_p2_vld <= r_p1_vld;
        end
        r_p1_sel <= i_cmd.mul_sel;
        r_p2_sel <= r_p1_sel;
        r_prod   <= ACC_W'(op_x * op_y);
        r_rnd    <= (r_prod + HALF) >>> FRAC_BITS;

        if (i_cmd.acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_cmd.acc_load) begin
            r_acc_re <= i_cmd.load_sub ? ACC_W'(a_re) - ACC_W'(b_re)
                                       : ACC_W'(a_re) + ACC_W'(b_re);
            r_acc_im <= i_cmd.load_sub ? ACC_W'(a_im) - ACC_W'(b_im)
                                       : ACC_W'(a_im) + ACC_W'(b_im);
        end else if (r_p2_vld) begin
            case (r_p2_sel)
                PP_RR:   r_acc_re <= r_acc_re + r_rnd;
                PP_II:   r_acc_re <= r_acc_re - r_rnd;
                default: r_acc_im <= r_acc_im + r_rnd;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_re   <= i_cmd.emit_err ? '0 : f_sat(r_acc_re);
            r_out_im   <= i_cmd.emit_err ? '0 : f_sat(r_acc_im);
            r_out_last <= i_cmd.emit_last;
            r_out_err  <= i_cmd.emit_err;
        end
    end

    assign o_sts.out_busy = r_out_vld && !i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_re       = r_out_re;
    assign o_out_im       = r_out_im;
    assign o_out_last     = r_out_last;
    assign o_out_err      = r_out_err;

    a_clr_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_clr |-> !r_p1_vld && !r_p2_vld)
        else $error("accumulator cleared with products in flight");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_p1_vld && !r_p2_vld)
        else $error("result taken before accumulate finished");
endmodule

FILE: design/cme_ctrl.sv
// Controller: config registers, load counter and the sequencer that walks
// result elements and their product terms. Depends on cme_pkg.
`timescale 1ns / 1ps

module cme_ctrl #(
    parameter int MAX_DIM = cme_pkg::MAX_DIM_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cme_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cme_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    output cme_pkg::t_dp_cmd                     o_cmd,
    input  cme_pkg::t_dp_sts                     i_sts,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_wr_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_wr_addr_b,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_rd_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_rd_addr_b
);
    import cme_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(2 * CELLS);
    localparam int TW    = CW + 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int PW    = 2 * DW;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [CFG_W-1:0]    r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_i, n_i, r_j, n_j, r_k, n_k, r_bi, n_bi, r_bj, n_bj;
    logic [AW-1:0]       r_abase, n_abase, r_bbase, n_bbase;
    logic [1:0]          r_ph, n_ph;
    logic                r_dcnt, n_dcnt;

    logic [DW-1:0]       ra, ca, rb, cb;
    logic [IW-1:0]       ra_m1, ca_m1, rb_m1, cb_m1;
    logic [TW-1:0]       na, nb, b_off;
    logic                in_acc, is_final, shape_bad, is_last;

    function automatic logic [DW-1:0] f_eff(input logic [CFG_W-1:0] d);
        if (d == '0) begin
            return DW'(1);
        end else if (int'(d) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(d);
    endfunction

    assign ra    = f_eff(r_rows_a);
    assign ca    = f_eff(r_cols_a);
    assign rb    = f_eff(r_rows_b);
    assign cb    = f_eff(r_cols_b);
    assign ra_m1 = IW'(ra - 1'b1);
    assign ca_m1 = IW'(ca - 1'b1);
    assign rb_m1 = IW'(rb - 1'b1);
    assign cb_m1 = IW'(cb - 1'b1);
    assign na    = TW'(TW'(ra) * TW'(ca));
    assign nb    = TW'(TW'(rb) * TW'(cb));

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_ADD;
            r_rows_a <= CFG_W'(1);
            r_cols_a <= CFG_W'(1);
            r_rows_b <= CFG_W'(1);
            r_cols_b <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OPERATION: r_op     <= t_op'(i_cfg_wdata[1:0]);
                CFG_ROWS_A:    r_rows_a <= i_cfg_wdata;
                CFG_COLS_A:    r_cols_a <= i_cfg_wdata;
                CFG_ROWS_B:    r_rows_b <= i_cfg_wdata;
                CFG_COLS_B:    r_cols_b <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // load side
    assign in_acc      = i_in_valid && (r_state == ST_LOAD);
    assign b_off       = TW'(r_count) - na;
    assign is_final    = (TW'(r_count) + 1'b1) >= (na + nb);
    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_wr_addr_a = AW'(r_count);
    assign o_wr_addr_b = AW'(b_off);

    always_comb begin
        unique case (r_op) inside
            OP_ADD, OP_SUB: shape_bad = (ra != rb) || (ca != cb);
            OP_MUL:         shape_bad = (ca != rb);
            default:        shape_bad = (PW'(ra) * PW'(rb) > PW'(MAX_DIM))
                                     || (PW'(ca) * PW'(cb) > PW'(MAX_DIM));
        endcase
    end

    always_comb begin
        unique case (r_op) inside
            OP_ADD, OP_SUB: is_last = (r_abase == AW'(na - 1'b1));
            OP_MUL:         is_last = (r_i == ra_m1) && (r_j == cb_m1);
            default:        is_last = (r_i == ra_m1) && (r_bi == rb_m1)
                                   && (r_j == ca_m1) && (r_bj == cb_m1);
        endcase
    end

    // read addresses follow the counters; they hold from READ through MUL
    always_comb begin
        unique case (r_op) inside
            OP_ADD, OP_SUB: begin
                o_rd_addr_a = r_abase;
                o_rd_addr_b = r_abase;
            end
            OP_MUL: begin
                o_rd_addr_a = r_abase + AW'(r_k);
                o_rd_addr_b = r_bbase;
            end
            default: begin
                o_rd_addr_a = r_abase + AW'(r_j);
                o_rd_addr_b = r_bbase + AW'(r_bj);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_bi    <= n_bi;
        r_bj    <= n_bj;
        r_abase <= n_abase;
        r_bbase <= n_bbase;
        r_ph    <= n_ph;
        r_dcnt  <= n_dcnt;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_bi    = r_bi;
        n_bj    = r_bj;
        n_abase = r_abase;
        n_bbase = r_bbase;
        n_ph    = r_ph;
        n_dcnt  = r_dcnt;
        o_cmd   = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    o_cmd.wr_a = TW'(r_count) < na;
                    o_cmd.wr_b = !(TW'(r_count) < na) && (b_off < TW'(CELLS));
                    if (is_final) begin
                        n_count = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_bi    = '0;
                        n_bj    = '0;
                        n_abase = '0;
                        n_bbase = '0;
                        n_state = shape_bad ? ST_ERR : ST_READ;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.acc_clr = (r_k == '0);
                n_ph          = '0;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                if (r_op == OP_ADD || r_op == OP_SUB) begin
                    o_cmd.acc_load = 1'b1;
                    o_cmd.load_sub = (r_op == OP_SUB);
                    n_state        = ST_EMIT;
                end else begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = t_pp'(r_ph);
                    n_ph          = r_ph + 1'b1;
                    if (r_ph == 2'd3) begin
                        if (r_op == OP_MUL && r_k != ca_m1) begin
                            n_k     = r_k + 1'b1;
                            n_bbase = r_bbase + AW'(cb);
                            n_state = ST_READ;
                        end else begin
                            n_dcnt  = 1'b0;
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                n_dcnt = 1'b1;
                if (r_dcnt) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = is_last;
                    n_state         = is_last ? ST_LOAD : ST_READ;
                    unique case (r_op) inside
                        OP_ADD, OP_SUB: n_abase = r_abase + 1'b1;
                        OP_MUL: begin
                            n_k = '0;
                            if (r_j == cb_m1) begin
                                n_j     = '0;
                                n_i     = r_i + 1'b1;
                                n_abase = r_abase + AW'(ca);
                                n_bbase = '0;
                            end else begin
                                n_j     = r_j + 1'b1;
                                n_bbase = AW'(r_j) + 1'b1;
                            end
                        end
                        default: begin
                            if (r_bj != cb_m1) begin
                                n_bj = r_bj + 1'b1;
                            end else begin
                                n_bj = '0;
                                if (r_j != ca_m1) begin
                                    n_j = r_j + 1'b1;
                                end else begin
                                    n_j = '0;
                                    if (r_bi == rb_m1) begin
                                        n_bi    = '0;
                                        n_bbase = '0;
                                        n_i     = r_i + 1'b1;
                                        n_abase = r_abase + AW'(ca);
                                    end else begin
                                        n_bi    = r_bi + 1'b1;
                                        n_bbase = r_bbase + AW'(cb);
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_ERR: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_err  = 1'b1;
                    n_state         = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result written over a waiting one");

    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == ST_LOAD))
        else $error("sequencer kept running after last element");

    a_one_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_a && o_cmd.wr_b))
        else $error("element written to both stores");

    a_store_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_a || o_cmd.wr_b) |-> (r_state == ST_LOAD) && i_in_valid)
        else $error("store written outside load");
endmodule

FILE: design/complex_matrix_engine_core.sv
// Top level of the complex matrix engine: config port, item channels,
// controller and datapath. Depends on cme_pkg, cme_if, cme_ctrl, cme_datapath.
`timescale 1ns / 1ps

// Complex matrix engine. Matrix A and then matrix B arrive one complex
// element per input item, row-major, with shapes taken from the rows_a,
// cols_a, rows_b and cols_b registers (0 reads as 1, values above MAX_DIM
// read as MAX_DIM). The item that completes B starts the configured
// operation (add, subtract, multiply, Kronecker product) and the result is
// streamed out row-major with last on its final element. Elements are signed
// fixed point with FRAC_BITS fraction bits; each partial product of a complex
// multiply is rounded half up, multiply sums at full width, and every result
// part saturates to 32 bits. Mismatched shapes, or a Kronecker result wider
// or taller than MAX_DIM, give one result of zero with shape_error and last.
// Loading takes every valid item. Compute uses one 32x32 multiplier, one
// partial product per cycle, behind two RAM stores with registered reads:
// add/subtract read both elements, load the sum or difference and emit it;
// multiply and Kronecker issue the partial products of each term, drain the
// multiplier pipeline and emit. Input items are not taken while a result
// matrix is computed; the output register lets loading of the next pair
// start while the final result still waits. Config must be written only
// while idle; the block does not enforce it. No clearing pass after reset.
module complex_matrix_engine_core #(
    parameter int MAX_DIM   = cme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cme_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cme_pkg::CFG_W-1:0]     i_cfg_wdata,
    cme_in_if.sink                        i_elem,
    cme_out_if.source                     o_res
);
    import cme_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [AW-1:0] wr_addr_a, wr_addr_b, rd_addr_a, rd_addr_b;

    // sequencer: owns config, load count and element/term counters
    cme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_elem.valid),
        .o_in_ready (i_elem.ready),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .o_wr_addr_a(wr_addr_a),
        .o_wr_addr_b(wr_addr_b),
        .o_rd_addr_a(rd_addr_a),
        .o_rd_addr_b(rd_addr_b)
    );

    // stores, multiplier pipeline, accumulator and result register
    cme_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_wr_addr_a(wr_addr_a),
        .i_wr_addr_b(wr_addr_b),
        .i_rd_addr_a(rd_addr_a),
        .i_rd_addr_b(rd_addr_b),
        .i_elem_re  (i_elem.elem_re),
        .i_elem_im  (i_elem.elem_im),
        .i_out_ready(o_res.ready),
        .o_out_valid(o_res.valid),
        .o_out_re   (o_res.out_re),
        .o_out_im   (o_res.out_im),
        .o_out_last (o_res.last),
        .o_out_err  (o_res.shape_error)
    );
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for complex_matrix_engine_core: loads A and B matrices,
// predicts add/subtract/multiply/Kronecker results and checks each result item.
// Depends on cme_pkg, cme_if and the design sources.
`timescale 1ns / 1ps

module testbench;
    import cme_pkg::*;

    localparam int DIM_LIMIT = 8;
    localparam int FRAC      = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int RAND_SETS = 12;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
        logic               err;
    } t_res;

    typedef struct {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } t_cpx;

    // one row of the directed table: a whole operation with its shapes;
    // single-result rows carry their expected item
    typedef struct {
        t_op        op;
        logic [3:0] ra, ca, rb, cb;
        int         fill;  // 0 random, 1 max positive, 2 min negative, 3 ones
        logic       typed;
        t_res       exp_res;
    } t_case;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    cme_in_if  elem_ch ();
    cme_out_if res_ch ();

    complex_matrix_engine_core dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_elem(elem_ch.sink), .o_res(res_ch.source)
    );

    // predictor state
    t_cpx         mat_a[64];
    t_cpx         mat_b[64];
    int           n_loaded;
    logic [1:0]   cur_op;
    logic [3:0]   cur_dim[4];
    t_res         pending_res[$];
    int           n_errors;
    int           idle_cycles;
    logic         rcv_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic int clamp_dim(input logic [3:0] d);
        if (d == 0) return 1;
        if (d > DIM_LIMIT) return DIM_LIMIT;
        return d;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // half-up rounding: arithmetic shift floors, so add half first
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] p);
        logic signed [63:0] x;
        x = p + (64'sd1 <<< (FRAC - 1));
        return x >>> FRAC;
    endfunction

    function automatic t_cpx cpx_mul(input t_cpx a, input t_cpx b);
        t_cpx r;
        r.re = round_frac(a.re * b.re) - round_frac(a.im * b.im);
        r.im = round_frac(a.re * b.im) + round_frac(a.im * b.re);
        return r;
    endfunction

    function automatic void push_res(input logic signed [63:0] re, im,
                                     input logic last, err);
        t_res r;
        r.re = sat32(re); r.im = sat32(im); r.last = last; r.err = err;
        pending_res.push_back(r);
    endfunction

    // predict on each accepted element; emits the matrix on the final one
    function automatic void predict_element(input logic signed [31:0] re, im);
        int ra, ca, rb, cb, na, nb, idx, n;
        t_cpx e, p;
        logic signed [63:0] sr, si;
        ra = clamp_dim(cur_dim[0]); ca = clamp_dim(cur_dim[1]);
        rb = clamp_dim(cur_dim[2]); cb = clamp_dim(cur_dim[3]);
        na = ra * ca; nb = rb * cb; idx = n_loaded;
        e.re = re; e.im = im;
        if (idx < na) mat_a[idx] = e;
        else if (idx - na < 64) mat_b[idx - na] = e;
        if (idx + 1 < na + nb) begin
            n_loaded = idx + 1;
            return;
        end
        n_loaded = 0;
        case (t_op'(cur_op))
            OP_ADD, OP_SUB: begin
                if (ra != rb || ca != cb) begin
                    push_res(0, 0, 1'b1, 1'b1);
                    return;
                end
                for (int i = 0; i < na; i++)
                    if (cur_op == OP_ADD)
                        push_res(mat_a[i].re + mat_b[i].re, mat_a[i].im + mat_b[i].im,
                                 i + 1 == na, 1'b0);
                    else
                        push_res(mat_a[i].re - mat_b[i].re, mat_a[i].im - mat_b[i].im,
                                 i + 1 == na, 1'b0);
            end
            OP_MUL: begin
                if (ca != rb) begin
                    push_res(0, 0, 1'b1, 1'b1);
                    return;
                end
                n = 0;
                for (int i = 0; i < ra; i++)
                    for (int j = 0; j < cb; j++) begin
                        sr = 0; si = 0;
                        for (int k = 0; k < ca; k++) begin
                            p = cpx_mul(mat_a[i*ca+k], mat_b[k*cb+j]);
                            sr += p.re; si += p.im;
                        end
                        n++;
                        push_res(sr, si, n == ra * cb, 1'b0);
                    end
            end
            default: begin
                if (ra * rb > DIM_LIMIT || ca * cb > DIM_LIMIT) begin
                    push_res(0, 0, 1'b1, 1'b1);
                    return;
                end
                n = 0;
                for (int r = 0; r < ra * rb; r++)
                    for (int c = 0; c < ca * cb; c++) begin
                        p = cpx_mul(mat_a[(r/rb)*ca + c/cb], mat_b[(r%rb)*cb + c%cb]);
                        n++;
                        push_res(p.re, p.im, n == ra * rb * ca * cb, 1'b0);
                    end
            end
        endcase
    endfunction

    // config write, one register per clock
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OPERATION) cur_op = val[1:0];
        else if (idx <= CFG_COLS_B) cur_dim[idx - 1] = val;
    endtask

    // block counts as idle once all expected results arrived and a spare wait passed
    task automatic wait_drained();
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_shape(input t_op op, input logic [3:0] ra, ca, rb, cb);
        wait_drained();
        write_reg(CFG_OPERATION, {2'b00, op});
        write_reg(CFG_ROWS_A, ra); write_reg(CFG_COLS_A, ca);
        write_reg(CFG_ROWS_B, rb); write_reg(CFG_COLS_B, cb);
    endtask

    // send one element; random gaps emulate a bursty source
    task automatic send_element(input logic signed [31:0] re, im);
        if ($urandom_range(0, 5) == 0) begin
            elem_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        elem_ch.valid <= 1'b1; elem_ch.elem_re <= re; elem_ch.elem_im <= im;
        @(posedge i_clk);
        while (!elem_ch.ready) @(posedge i_clk);
        predict_element(re, im);
    endtask

    function automatic logic [31:0] rand_val(input int fill);
        case (fill)
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 32'h00010000;
            default:
                case ($urandom_range(0, 5))
                    0: return $urandom();
                    1: return 32'h7fffffff - $urandom_range(0, 3);
                    2: return 32'h80000000 + $urandom_range(0, 3);
                    default: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
                endcase
        endcase
    endfunction

    task automatic run_matrices(input int fill);
        int total;
        total = clamp_dim(cur_dim[0]) * clamp_dim(cur_dim[1])
              + clamp_dim(cur_dim[2]) * clamp_dim(cur_dim[3]);
        for (int i = 0; i < total; i++) send_element(rand_val(fill), rand_val(fill));
        elem_ch.valid <= 1'b0;
    endtask

    t_case dir_tab[] = '{
        '{OP_ADD,  4'd1, 4'd1, 4'd1, 4'd1, 1, 1'b1,         // saturate positive
          '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0}},
        '{OP_SUB,  4'd1, 4'd1, 4'd1, 4'd1, 2, 1'b1,         // min minus min
          '{32'sh0, 32'sh0, 1'b1, 1'b0}},
        '{OP_ADD,  4'd2, 4'd2, 4'd2, 4'd2, 2, 1'b0,         // saturate negative
          '{32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_MUL,  4'd2, 4'd3, 4'd3, 4'd2, 0, 1'b0,
          '{32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_KRON, 4'd2, 4'd2, 4'd2, 4'd2, 3, 1'b0,
          '{32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_ADD,  4'd0, 4'd0, 4'd0, 4'd0, 0, 1'b0,         // zero dims read as one
          '{32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_MUL,  4'd15, 4'd1, 4'd1, 4'd9, 0, 1'b0,        // oversize dims clamp
          '{32'sh0, 32'sh0, 1'b0, 1'b0}},
        '{OP_KRON, 4'd3, 4'd3, 4'd3, 4'd3, 0, 1'b1,         // Kronecker too large
          '{32'sh0, 32'sh0, 1'b1, 1'b1}},
        '{OP_MUL,  4'd2, 4'd2, 4'd3, 4'd1, 0, 1'b1,         // inner dims differ
          '{32'sh0, 32'sh0, 1'b1, 1'b1}},
        '{OP_SUB,  4'd2, 4'd1, 4'd1, 4'd2, 0, 1'b1,         // shapes differ
          '{32'sh0, 32'sh0, 1'b1, 1'b1}}
    };

    // receiver with its own stall pattern; checks in order
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            rcv_stall   <= 1'b0;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= (rcv_stall ? 60 : 5));
            if ($urandom_range(0, 63) == 0) rcv_stall <= ~rcv_stall;
            if (res_ch.valid && res_ch.ready) begin
                if (pending_res.size() == 0) report_mismatch("unexpected result item");
                else begin
                    exp_r = pending_res.pop_front();
                    if (res_ch.out_re !== exp_r.re)
                        report_mismatch($sformatf("re %h exp %h", res_ch.out_re, exp_r.re));
                    if (res_ch.out_im !== exp_r.im)
                        report_mismatch($sformatf("im %h exp %h", res_ch.out_im, exp_r.im));
                    if (res_ch.last !== exp_r.last) report_mismatch("last flag");
                    if (res_ch.shape_error !== exp_r.err) report_mismatch("shape_error flag");
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [3:0] d[4];
        n_errors = 0; idle_cycles = 0; n_loaded = 0;
        cur_op = OP_ADD; cur_dim = '{4'd1, 4'd1, 4'd1, 4'd1};
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        elem_ch.valid = 1'b0; elem_ch.elem_re = '0; elem_ch.elem_im = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shapes are 1x1 add: one item each
        run_matrices(0);

        foreach (dir_tab[i]) begin
            set_shape(dir_tab[i].op, dir_tab[i].ra, dir_tab[i].ca,
                      dir_tab[i].rb, dir_tab[i].cb);
            run_matrices(dir_tab[i].fill);
            // single-result rows are checked against the value in the table
            if (dir_tab[i].typed) begin
                pending_res.delete();
                pending_res.push_back(dir_tab[i].exp_res);
            end
        end

        // random part: mostly valid shapes, small sizes, some mismatches
        for (int s = 0; s < RAND_SETS; s++) begin
            t_op op;
            op = t_op'($urandom_range(0, 3));
            foreach (d[k]) d[k] = $urandom_range(1, 3);
            if ($urandom_range(0, 4) != 0)
                case (op)
                    OP_ADD, OP_SUB: begin d[2] = d[0]; d[3] = d[1]; end
                    OP_MUL: d[2] = d[1];
                    default: begin d[0] = $urandom_range(1, 2); d[2] = $urandom_range(1, 4);
                        d[1] = $urandom_range(1, 2); d[3] = $urandom_range(1, 4); end
                endcase
            // full inner dimension, and a Kronecker at the size limit
            if (s == 3) begin op = OP_MUL; d = '{4'd4, 4'd8, 4'd8, 4'd2}; end
            if (s == 9) begin op = OP_KRON; d = '{4'd1, 4'd8, 4'd8, 4'd1}; end
            set_shape(op, d[0], d[1], d[2], d[3]);
            run_matrices(0);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
